// ----- hdl/eyvm_pkg.sv -----
// ----------------------------------------------------------------------------
// eyvm_pkg: shared constants and arithmetic helpers for the YXZ view basis
// Holds the sine polynomial constants and the rounding multiply.
// ----------------------------------------------------------------------------
package eyvm_pkg;

  localparam int TurnScale = 166886;
  localparam int Q14One    = 16384;
  localparam int SinA      = 25736;
  localparam int SinB      = 10512;
  localparam int SinC      = 1160;

  localparam int InTdataW  = 144;
  localparam int OutTdataW = 88;

  // Q14 multiply, rounds half up
  function automatic logic signed [17:0] qmul(input logic signed [17:0] a,
                                              input logic signed [17:0] b);
    logic signed [35:0] p;
    p = a * b + 36'sd8192;
    return 18'(p >>> 14);
  endfunction

  // clamp to [-1, 1] in Q14
  function automatic logic signed [15:0] clampb(input logic signed [17:0] v);
    if (v > 18'sd16384) return 16'sd16384;
    if (v < -18'sd16384) return -16'sd16384;
    return 16'(v);
  endfunction

endpackage

// ----- hdl/euler_yxz_view_matrix_top.sv -----
// ----------------------------------------------------------------------------
// euler_yxz_view_matrix_top: YXZ Euler camera view basis rows
// An accepted item passes through the registered stages below to out_tvalid;
// its rows follow 1/cycle while out_tready is high. Items flow at the pace of
// the three-row output serializer. All stages advance together and hold while
// the serializer still has rows to send.
// Reset: synchronous active-low rst_n clears valid bits and the row counter.
// ----------------------------------------------------------------------------
module euler_yxz_view_matrix_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pitch_angle[15:0], yaw_angle[31:16], roll_angle[47:32],
  // pos_x[79:48], pos_y[111:80], pos_z[143:112]
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // row_index[1:0], basis_x[17:2], basis_y[33:18], basis_z[49:34],
  // offset[81:50], zero fill [87:82]
  output logic [87:0]  out_tdata,
  output logic         out_tlast
);

  // pipeline advances when the serializer is empty or sends its last row
  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;

  // stage 1: angle to phase product
  logic signed [35:0] ph_r [3];
  logic signed [31:0] px1_r, py1_r, pz1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++)
        ph_r[i] <= 36'(signed'(in_tdata[16*i +: 16])) * 36'sd166886 + 36'sd32768;
      px1_r <= in_tdata[79:48];
      py1_r <= in_tdata[111:80];
      pz1_r <= in_tdata[143:112];
    end
  end

  // stage 2: folded arguments, x2 = x*x>>14
  logic [15:0] p2 [6];
  logic [14:0] x2a_r [6];
  logic [13:0] x2s_r [6];
  logic [1:0]  q2_r  [6];
  logic signed [31:0] px2_r, py2_r, pz2_r;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p2[2*i]   = ph_r[i][31:16];
      p2[2*i+1] = ph_r[i][31:16] + 16'd16384;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        logic [14:0] x;
        logic [29:0] xx;
        x  = p2[k][14] ? 15'd16384 - 15'(p2[k][13:0]) : 15'(p2[k][13:0]);
        xx = x * x;
        x2a_r[k] <= x;
        x2s_r[k] <= 14'(xx >> 14) | {14{xx[28]}};
        q2_r[k]  <= p2[k][15:14];
      end
      px2_r <= px1_r; py2_r <= py1_r; pz2_r <= pz1_r;
    end
  end

  // stage 3: t = SinB - (SinC*x2>>14)
  logic [14:0] x3_r [6];
  logic [14:0] x23_r [6];
  logic [13:0] t3_r [6];
  logic [1:0]  q3_r [6];
  logic signed [31:0] px3_r, py3_r, pz3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        logic [25:0] m;
        logic [14:0] xx2;
        xx2 = (x2a_r[k] == 15'd16384) ? 15'd16384 : {1'b0, x2s_r[k]};
        m = 26'(eyvm_pkg::SinC) * 26'(xx2);
        t3_r[k]  <= 14'(eyvm_pkg::SinB) - 14'(m >> 14);
        x23_r[k] <= xx2;
        x3_r[k]  <= x2a_r[k];
        q3_r[k]  <= q2_r[k];
      end
      px3_r <= px2_r; py3_r <= py2_r; pz3_r <= pz2_r;
    end
  end

  // stage 4: t = SinA - (t*x2>>14)
  logic [14:0] x4_r [6];
  logic [14:0] t4_r [6];
  logic [1:0]  q4_r [6];
  logic signed [31:0] px4_r, py4_r, pz4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        logic [28:0] m;
        m = 29'(t3_r[k]) * 29'(x23_r[k]);
        t4_r[k] <= 15'(eyvm_pkg::SinA) - 15'(m >> 14);
        x4_r[k] <= x3_r[k];
        q4_r[k] <= q3_r[k];
      end
      px4_r <= px3_r; py4_r <= py3_r; pz4_r <= pz3_r;
    end
  end

  // stage 5: y = t*x>>14, signed by quadrant; order s1 s2 s3 (yaw pitch roll)
  logic signed [17:0] sn_r [6];
  logic signed [31:0] px5_r, py5_r, pz5_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        logic [29:0] m;
        logic [17:0] y;
        m = 30'(t4_r[k]) * 30'(x4_r[k]);
        y = 18'(m >> 14);
        sn_r[k] <= q4_r[k][1] ? -signed'(y) : signed'(y);
      end
      px5_r <= px4_r; py5_r <= py4_r; pz5_r <= pz4_r;
    end
  end
  // k: 0 sin pitch,1 cos pitch,2 sin yaw,3 cos yaw,4 sin roll,5 cos roll
  logic signed [17:0] s1, c1, s2, c2, s3, c3;
  assign s2 = sn_r[0]; assign c2 = sn_r[1];
  assign s1 = sn_r[2]; assign c1 = sn_r[3];
  assign s3 = sn_r[4]; assign c3 = sn_r[5];

  // stage 6: first-level products
  logic signed [17:0] c1c3_r, s1s2_r, c2s3_r, c1s2_r, c3s1_r, c1s3_r;
  logic signed [17:0] c2c3_r, s1s3_r, c2s1_r, ns2_r, c1c2_r, s2_6r, s3_6r;
  logic signed [31:0] px6_r, py6_r, pz6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      c1c3_r <= eyvm_pkg::qmul(c1, c3);
      s1s2_r <= eyvm_pkg::qmul(s1, s2);
      c2s3_r <= eyvm_pkg::qmul(c2, s3);
      c1s2_r <= eyvm_pkg::qmul(c1, s2);
      c3s1_r <= eyvm_pkg::qmul(c3, s1);
      c1s3_r <= eyvm_pkg::qmul(c1, s3);
      c2c3_r <= eyvm_pkg::qmul(c2, c3);
      s1s3_r <= eyvm_pkg::qmul(s1, s3);
      c2s1_r <= eyvm_pkg::qmul(c2, s1);
      c1c2_r <= eyvm_pkg::qmul(c1, c2);
      ns2_r  <= -s2;
      s2_6r  <= s2;
      s3_6r  <= s3;
      px6_r <= px5_r; py6_r <= py5_r; pz6_r <= pz5_r;
    end
  end

  // stage 7: second-level products, sums and clamps
  logic signed [15:0] b_r [9];
  logic signed [31:0] px7_r, py7_r, pz7_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      b_r[0] <= eyvm_pkg::clampb(c1c3_r + eyvm_pkg::qmul(s1s2_r, s3_6r));
      b_r[1] <= eyvm_pkg::clampb(c2s3_r);
      b_r[2] <= eyvm_pkg::clampb(eyvm_pkg::qmul(c1s2_r, s3_6r) - c3s1_r);
      b_r[3] <= eyvm_pkg::clampb(eyvm_pkg::qmul(c3s1_r, s2_6r) - c1s3_r);
      b_r[4] <= eyvm_pkg::clampb(c2c3_r);
      b_r[5] <= eyvm_pkg::clampb(eyvm_pkg::qmul(c1c3_r, s2_6r) + s1s3_r);
      b_r[6] <= eyvm_pkg::clampb(c2s1_r);
      b_r[7] <= eyvm_pkg::clampb(ns2_r);
      b_r[8] <= eyvm_pkg::clampb(c1c2_r);
      px7_r <= px6_r; py7_r <= py6_r; pz7_r <= pz6_r;
    end
  end

  // stage 8: dot-product terms, 9 products
  logic signed [47:0] pr_r [9];
  logic signed [15:0] b8_r [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        pr_r[3*r]   <= 48'(b_r[3*r])   * 48'(px7_r);
        pr_r[3*r+1] <= 48'(b_r[3*r+1]) * 48'(py7_r);
        pr_r[3*r+2] <= 48'(b_r[3*r+2]) * 48'(pz7_r);
      end
      for (int k = 0; k < 9; k++) b8_r[k] <= b_r[k];
    end
  end

  // stage 9: offsets, round and saturate
  logic signed [31:0] off_r [3];
  logic signed [15:0] b9_r [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        logic signed [50:0] s, o;
        s = 51'(pr_r[3*r]) + 51'(pr_r[3*r+1]) + 51'(pr_r[3*r+2]);
        o = (-s + 51'sd8192) >>> 14;
        if (o > 51'sd2147483647) off_r[r] <= 32'sh7fffffff;
        else if (o < -51'sd2147483648) off_r[r] <= 32'sh80000000;
        else off_r[r] <= 32'(o);
      end
      for (int k = 0; k < 9; k++) b9_r[k] <= b8_r[k];
    end
  end

  // output serializer: holds one item, emits three rows
  logic       ov_r;
  logic [1:0] row_r;
  logic       done;
  assign done = ov_r && out_tready && (row_r == 2'd2);
  assign adv  = !ov_r || done;
  assign in_tready = adv;

  logic v8_r, v9_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r} <= '0;
    end else if (adv) begin
      v1_r <= in_tvalid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r; v9_r <= v8_r;
    end
  end

  // v9 is the item sitting in the serializer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= 2'd0;
    end else if (ov_r && out_tready) begin
      row_r <= (row_r == 2'd2) ? 2'd0 : row_r + 2'd1;
    end
  end
  assign ov_r = v9_r;

  assign out_tvalid = ov_r;
  assign out_tlast  = (row_r == 2'd2);
  always_comb begin
    logic [1:0] rr;
    rr = (row_r == 2'd3) ? 2'd0 : row_r;
    out_tdata = {6'd0, off_r[rr], b9_r[3*rr+2], b9_r[3*rr+1], b9_r[3*rr], row_r};
  end

endmodule
